// File: hdl/rbsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsm_pkg : shared types and constants of the ring buffer space manager
// Widths, action / status / register codes and controller command word.
// ----------------------------------------------------------------------------
package rbsm_pkg;

    localparam int MAX_BYTES = 65536;

    localparam int POS_W   = 17;   // offsets, sizes and byte counts
    localparam int FILL_W  = 18;   // fill count
    localparam int OFF_W   = 16;   // offsets as reported
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W   = 17;

    localparam logic [POS_W-1:0]  MAX_SIZE = POS_W'(MAX_BYTES);
    localparam logic [FILL_W-1:0] FILL_MAX = {FILL_W{1'b1}};

    typedef enum logic [2:0] {
        ACT_RESERVE = 3'd0,
        ACT_COMMIT  = 3'd1,
        ACT_FREE    = 3'd2,
        ACT_READ    = 3'd3,
        ACT_CANCEL  = 3'd4,
        ACT_STOP    = 3'd5,
        ACT_RESET   = 3'd6,
        ACT_FLUSH   = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_INVALID     = 3'd1,
        ST_NOT_ACTIVE  = 3'd2,
        ST_WOULD_BLOCK = 3'd3,
        ST_SHORT_READ  = 3'd4,
        ST_NO_ACCUM    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        WM_NONE = 2'd0,
        WM_HIGH = 2'd1,
        WM_LOW  = 2'd2
    } t_wm_event;

    typedef enum logic [1:0] {
        RUN_ACTIVE   = 2'd0,
        RUN_CANCELED = 2'd1,
        RUN_STOPPED  = 2'd2
    } t_run;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUFFER_BYTES = 3'd0,
        CFG_ACC_WINDOW   = 3'd1,
        CFG_NOTIFY_EN    = 3'd2,
        CFG_WM_EN        = 3'd3,
        CFG_WM_LOW       = 3'd4,
        CFG_WM_HIGH      = 3'd5
    } t_cfg_idx;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the incoming word
        logic execute;   // apply the latched action, register the result
    } t_dp_cmd;

endpackage

// File: hdl/rbsm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsm_ctrl : sequencing of the space manager
// Takes a request word, lets the datapath execute it, holds the result word.
// ----------------------------------------------------------------------------
module rbsm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rbsm_pkg::t_dp_cmd o_cmd
);
    import rbsm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: n_state = S_DONE;
            S_DONE: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_DONE);
    assign o_cmd.capture = i_in_valid && (r_state == S_IDLE);
    assign o_cmd.execute = (r_state == S_EXEC);

endmodule

// File: hdl/rbsm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsm_dp : offsets, fill count, configuration and result registers
// Evaluates one action per execute command against the registered state.
// ----------------------------------------------------------------------------
module rbsm_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rbsm_pkg::t_dp_cmd                 i_cmd,
    input  logic                              i_cfg_wen,
    input  logic [rbsm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rbsm_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic [2:0]                        i_action,
    input  logic [rbsm_pkg::POS_W-1:0]        i_request_bytes,
    input  logic [rbsm_pkg::OFF_W-1:0]        i_chunk_offset,
    output logic [2:0]                        o_status,
    output logic [rbsm_pkg::OFF_W-1:0]        o_grant_offset,
    output logic [rbsm_pkg::POS_W-1:0]        o_grant_bytes,
    output logic [1:0]                        o_wm_event,
    output logic                              o_notify_valid,
    output logic [rbsm_pkg::OFF_W-1:0]        o_notify_offset,
    output logic [rbsm_pkg::POS_W-1:0]        o_notify_bytes,
    output logic [rbsm_pkg::FILL_W-1:0]       o_fill_bytes
);
    import rbsm_pkg::*;

    // configuration
    logic [POS_W-1:0] r_buf_bytes, r_acc_win, r_wm_low, r_wm_high;
    logic             r_notify_en, r_wm_en;

    // latched request
    t_action          r_act;
    logic [POS_W-1:0] r_req;
    logic [OFF_W-1:0] r_coff;

    // buffer state
    logic [POS_W-1:0]  r_rpos, n_rpos, r_wpos, n_wpos, r_cpos, n_cpos, r_eod, n_eod;
    logic              r_eod_v, n_eod_v, r_wm_lvl, n_wm_lvl;
    logic [FILL_W-1:0] r_fill, n_fill;
    t_run              r_run, n_run;

    // result
    t_status           r_status, n_status;
    logic [OFF_W-1:0]  r_goff, n_goff, r_noff, n_noff;
    logic [POS_W-1:0]  r_gbytes, n_gbytes, r_nbytes, n_nbytes;
    t_wm_event         r_wev, n_wev;
    logic              r_nval, n_nval;

    // helpers
    logic [POS_W-1:0]  size, eod_gap, rd_len;
    logic              win_on, empty, wm_ok, notif_on, eod_hit;
    logic [FILL_W-1:0] wsum, csum, cm_nb, rd_short;
    logic [FILL_W:0]   fsum, cfsum;
    logic [FILL_W-1:0] fill_sat, wm_fill;
    t_wm_event         wm_ev;
    logic              wm_lvl_nx;

    always_comb begin
        if (r_buf_bytes == '0)            size = POS_W'(1);
        else if (r_buf_bytes > MAX_SIZE)  size = MAX_SIZE;
        else                              size = r_buf_bytes;
    end

    assign win_on   = (r_acc_win != '0) && (r_acc_win <= (size >> 1));
    assign notif_on = win_on && r_notify_en;
    assign empty    = (r_wpos == r_rpos) && (r_fill == '0);
    assign wm_ok    = r_wm_en && (r_wm_high <= size) && (r_wm_low <= r_wm_high);

    assign wsum = {1'b0, r_wpos} + {1'b0, r_req};
    assign csum = {1'b0, r_cpos} + {1'b0, r_req};

    assign fsum     = {1'b0, r_fill} + {2'b00, r_req};
    assign fill_sat = (fsum > {1'b0, FILL_MAX}) ? FILL_MAX : fsum[FILL_W-1:0];
    assign cfsum    = {2'b00, r_cpos} + {1'b0, fill_sat};
    assign cm_nb    = fill_sat - {1'b0, r_req};

    assign eod_hit  = r_eod_v && (csum > {1'b0, r_eod});
    assign eod_gap  = (r_eod > r_cpos) ? (r_eod - r_cpos) : '0;
    assign rd_len   = (eod_gap == '0) ? r_req : eod_gap;
    assign rd_short = ({1'b0, r_req} > r_fill) ? r_fill : {1'b0, r_req};

    // hysteresis on the fill seen after the action
    assign wm_fill = (r_act == ACT_COMMIT) ? fill_sat : r_fill;
    always_comb begin
        wm_ev     = WM_NONE;
        wm_lvl_nx = r_wm_lvl;
        if (wm_ok) begin
            if (wm_fill > {1'b0, r_wm_high} && !r_wm_lvl) begin
                wm_ev     = WM_HIGH;
                wm_lvl_nx = 1'b1;
            end else if (wm_fill < {1'b0, r_wm_low} && r_wm_lvl) begin
                wm_ev     = WM_LOW;
                wm_lvl_nx = 1'b0;
            end
        end
    end

    always_comb begin
        n_rpos   = r_rpos;
        n_wpos   = r_wpos;
        n_cpos   = r_cpos;
        n_eod    = r_eod;
        n_eod_v  = r_eod_v;
        n_fill   = r_fill;
        n_run    = r_run;
        n_wm_lvl = r_wm_lvl;
        n_status = ST_OK;
        n_goff   = '0;
        n_gbytes = '0;
        n_wev    = WM_NONE;
        n_nval   = 1'b0;
        n_noff   = '0;
        n_nbytes = '0;
        unique case (r_act)
            ACT_RESERVE: begin
                if (r_req > size) begin
                    n_status = ST_INVALID;
                end else if (r_run != RUN_ACTIVE) begin
                    n_status = ST_NOT_ACTIVE;
                end else if (wsum <= {1'b0, size}) begin
                    if (r_wpos <= r_rpos && wsum > {1'b0, r_rpos} && !empty) begin
                        n_status = ST_WOULD_BLOCK;
                    end else begin
                        n_goff = r_wpos[OFF_W-1:0];
                        n_wpos = wsum[POS_W-1:0];
                    end
                end else begin
                    // no room before the end: wrap to the start, mark end of data
                    if ((r_rpos < r_req || r_rpos >= r_wpos) && !empty) begin
                        n_status = ST_WOULD_BLOCK;
                    end else begin
                        n_eod   = r_wpos;
                        n_eod_v = 1'b1;
                        n_wpos  = r_req;
                    end
                end
            end
            ACT_COMMIT: begin
                n_fill = fill_sat;
                if (fill_sat > {1'b0, size}) begin
                    n_status = ST_INVALID;
                end else begin
                    n_wev    = wm_ev;
                    n_wm_lvl = wm_lvl_nx;
                    if (notif_on) begin
                        if (cfsum > {2'b00, size}) begin
                            n_nval   = 1'b1;
                            n_noff   = r_cpos[OFF_W-1:0];
                            n_nbytes = cm_nb[POS_W-1:0];
                            n_fill   = {1'b0, r_req};
                            n_cpos   = '0;
                        end else if (fill_sat >= {1'b0, r_acc_win}) begin
                            n_nval   = 1'b1;
                            n_noff   = r_cpos[OFF_W-1:0];
                            n_nbytes = cm_nb[POS_W-1:0];
                            n_fill   = {1'b0, r_req};
                            n_cpos   = r_cpos + cm_nb[POS_W-1:0];
                        end
                    end
                end
            end
            ACT_FREE: begin
                n_rpos   = {1'b0, r_coff} + r_req;
                n_wev    = wm_ev;
                n_wm_lvl = wm_lvl_nx;
            end
            ACT_READ: begin
                if (r_req > size) begin
                    n_status = ST_INVALID;
                end else if ({1'b0, r_req} > r_fill && r_run != RUN_STOPPED) begin
                    n_status = (r_run == RUN_ACTIVE) ? ST_WOULD_BLOCK : ST_NOT_ACTIVE;
                end else if (eod_hit) begin
                    // only the bytes up to the mark, or a fresh start at zero
                    n_goff   = (eod_gap == '0) ? '0 : r_cpos[OFF_W-1:0];
                    n_cpos   = (eod_gap == '0) ? r_req : '0;
                    n_fill   = (r_fill > {1'b0, rd_len}) ? (r_fill - {1'b0, rd_len}) : '0;
                    n_eod_v  = 1'b0;
                    n_eod    = '0;
                    n_gbytes = rd_len;
                end else begin
                    n_goff = r_cpos[OFF_W-1:0];
                    if (r_run == RUN_STOPPED && {1'b0, r_req} > r_fill) begin
                        n_status = ST_SHORT_READ;
                    end
                    n_fill   = r_fill - rd_short;
                    n_cpos   = r_cpos + rd_short[POS_W-1:0];
                    n_gbytes = rd_short[POS_W-1:0];
                end
            end
            ACT_CANCEL: begin
                n_run  = RUN_CANCELED;
                n_fill = '0;
            end
            ACT_STOP: begin
                n_run = RUN_STOPPED;
            end
            ACT_RESET: begin
                n_rpos   = '0;
                n_wpos   = '0;
                n_cpos   = '0;
                n_eod    = '0;
                n_eod_v  = 1'b0;
                n_fill   = '0;
                n_wm_lvl = 1'b0;
                n_run    = RUN_ACTIVE;
            end
            ACT_FLUSH: begin
                if (!win_on && !r_notify_en) begin
                    n_status = ST_NO_ACCUM;
                end else if (r_fill != '0 && notif_on) begin
                    n_nval   = 1'b1;
                    n_noff   = r_cpos[OFF_W-1:0];
                    n_nbytes = r_fill[POS_W-1:0];
                end
            end
            default: n_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_bytes <= MAX_SIZE;
            r_acc_win   <= '0;
            r_notify_en <= 1'b0;
            r_wm_en     <= 1'b0;
            r_wm_low    <= '0;
            r_wm_high   <= '0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_index)
                CFG_BUFFER_BYTES: r_buf_bytes <= i_cfg_data;
                CFG_ACC_WINDOW:   r_acc_win   <= i_cfg_data;
                CFG_NOTIFY_EN:    r_notify_en <= i_cfg_data[0];
                CFG_WM_EN:        r_wm_en     <= i_cfg_data[0];
                CFG_WM_LOW:       r_wm_low    <= i_cfg_data;
                CFG_WM_HIGH:      r_wm_high   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpos   <= '0;
            r_wpos   <= '0;
            r_cpos   <= '0;
            r_eod    <= '0;
            r_eod_v  <= 1'b0;
            r_fill   <= '0;
            r_run    <= RUN_ACTIVE;
            r_wm_lvl <= 1'b0;
        end else if (i_cmd.execute) begin
            r_rpos   <= n_rpos;
            r_wpos   <= n_wpos;
            r_cpos   <= n_cpos;
            r_eod    <= n_eod;
            r_eod_v  <= n_eod_v;
            r_fill   <= n_fill;
            r_run    <= n_run;
            r_wm_lvl <= n_wm_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act  <= t_action'(i_action);
            r_req  <= i_request_bytes;
            r_coff <= i_chunk_offset;
        end
        if (i_cmd.execute) begin
            r_status <= n_status;
            r_goff   <= n_goff;
            r_gbytes <= n_gbytes;
            r_wev    <= n_wev;
            r_nval   <= n_nval;
            r_noff   <= n_noff;
            r_nbytes <= n_nbytes;
        end
    end

    assign o_status        = r_status;
    assign o_grant_offset  = r_goff;
    assign o_grant_bytes   = r_gbytes;
    assign o_wm_event      = r_wev;
    assign o_notify_valid  = r_nval;
    assign o_notify_offset = r_noff;
    assign o_notify_bytes  = r_nbytes;
    assign o_fill_bytes    = r_fill;

endmodule

// File: hdl/ring_buffer_space_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_space_manager : offset bookkeeping of a contiguous-chunk ring
// Reserve / commit / free / read / cancel / stop / reset / flush, one result
// word per request word, with watermark and accumulation-window reporting.
// ----------------------------------------------------------------------------
// Each request word passes through S_IDLE, in which it is accepted, S_EXEC,
// in which the datapath evaluates the action against the registered offsets
// and fill count, and S_DONE, where the result word is offered. A new request
// is taken only after the previous result has been accepted, since every
// action reads the state left by the one before. Configuration writes take
// effect at the clock edge of the write and must be made while idle.
module ring_buffer_space_manager (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wen,
    input  logic [rbsm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rbsm_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [2:0]                        i_action,
    input  logic [rbsm_pkg::POS_W-1:0]        i_request_bytes,
    input  logic [rbsm_pkg::OFF_W-1:0]        i_chunk_offset,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [2:0]                        o_status,
    output logic [rbsm_pkg::OFF_W-1:0]        o_grant_offset,
    output logic [rbsm_pkg::POS_W-1:0]        o_grant_bytes,
    output logic [1:0]                        o_wm_event,
    output logic                              o_notify_valid,
    output logic [rbsm_pkg::OFF_W-1:0]        o_notify_offset,
    output logic [rbsm_pkg::POS_W-1:0]        o_notify_bytes,
    output logic [rbsm_pkg::FILL_W-1:0]       o_fill_bytes
);
    import rbsm_pkg::*;

    t_dp_cmd cmd;

    rbsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    rbsm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_action),
        .i_request_bytes (i_request_bytes),
        .i_chunk_offset  (i_chunk_offset),
        .o_status        (o_status),
        .o_grant_offset  (o_grant_offset),
        .o_grant_bytes   (o_grant_bytes),
        .o_wm_event      (o_wm_event),
        .o_notify_valid  (o_notify_valid),
        .o_notify_offset (o_notify_offset),
        .o_notify_bytes  (o_notify_bytes),
        .o_fill_bytes    (o_fill_bytes)
    );

    // one word in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("request and result side open together");

    // a taken request passes through S_EXEC before its result is offered
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> ##1 o_out_valid)
        else $error("result word missing after request");

    // a blocked request hands out nothing
    a_block_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_WOULD_BLOCK) |->
            (o_grant_bytes == '0 && !o_notify_valid && o_wm_event == WM_NONE))
        else $error("would-block result carries a grant or event");

    // watermark events only in their defined codes
    a_wm_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_wm_event == WM_NONE || o_wm_event == WM_HIGH ||
                         o_wm_event == WM_LOW))
        else $error("bad watermark event code");

endmodule

// File: verif/ring_buffer_space_manager_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_space_manager_test : self-checking bench of the space manager
// Drives request words through the valid/ready port with random gaps and
// result back-pressure. A behavioural copy of the offset bookkeeping
// predicts every result word, which is compared field by field in order.
// Directed edge cases come first, then random traffic under a range of
// buffer, watermark and accumulation settings.
// ----------------------------------------------------------------------------
module ring_buffer_space_manager_test;
    import rbsm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 800000;

    typedef struct {
        t_status             status;
        logic [OFF_W-1:0]    goff;
        logic [POS_W-1:0]    gbytes;
        t_wm_event           wev;
        logic                nval;
        logic [OFF_W-1:0]    noff;
        logic [POS_W-1:0]    nbytes;
        logic [FILL_W-1:0]   fill;
    } t_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wen;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [2:0]             i_action;
    logic [POS_W-1:0]       i_request_bytes;
    logic [OFF_W-1:0]       i_chunk_offset;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [2:0]             o_status;
    logic [OFF_W-1:0]       o_grant_offset;
    logic [POS_W-1:0]       o_grant_bytes;
    logic [1:0]             o_wm_event;
    logic                   o_notify_valid;
    logic [OFF_W-1:0]       o_notify_offset;
    logic [POS_W-1:0]       o_notify_bytes;
    logic [FILL_W-1:0]      o_fill_bytes;

    // settings copy
    logic [POS_W-1:0]   cfg_size, cfg_window, cfg_wm_low, cfg_wm_high;
    logic               cfg_notify, cfg_wm_en;
    // bookkeeping copy
    logic [POS_W-1:0]   rd_pos, wr_pos, use_pos, mark_pos;
    logic               mark_valid;
    logic [FILL_W-1:0]  fill_level;
    t_run               run_mode;
    logic               level_high;

    t_result            due_results[$];
    t_result            last_result;
    int unsigned        words_sent;
    int unsigned        results_seen;
    int unsigned        mismatches;
    int unsigned        cycle_count;
    bit                 steady;

    ring_buffer_space_manager u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_request_bytes (i_request_bytes),
        .i_chunk_offset  (i_chunk_offset),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_grant_offset  (o_grant_offset),
        .o_grant_bytes   (o_grant_bytes),
        .o_wm_event      (o_wm_event),
        .o_notify_valid  (o_notify_valid),
        .o_notify_offset (o_notify_offset),
        .o_notify_bytes  (o_notify_bytes),
        .o_fill_bytes    (o_fill_bytes)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int unsigned size_in_use();
        if (cfg_size == 0) return 1;
        if (cfg_size > MAX_SIZE) return MAX_BYTES;
        return cfg_size;
    endfunction

    function automatic bit window_open();
        return cfg_window != 0 && cfg_window <= size_in_use() / 2;
    endfunction

    // hysteresis: only report a crossing opposite to the current level
    function automatic t_wm_event level_crossing();
        if (!cfg_wm_en || cfg_wm_high > size_in_use() || cfg_wm_low > cfg_wm_high)
            return WM_NONE;
        if (fill_level > cfg_wm_high && !level_high) begin
            level_high = 1'b1;
            return WM_HIGH;
        end
        if (fill_level < cfg_wm_low && level_high) begin
            level_high = 1'b0;
            return WM_LOW;
        end
        return WM_NONE;
    endfunction

    function automatic void clear_offsets();
        rd_pos     = '0;
        wr_pos     = '0;
        use_pos    = '0;
        mark_pos   = '0;
        mark_valid = 1'b0;
        fill_level = '0;
        level_high = 1'b0;
        run_mode   = RUN_ACTIVE;
    endfunction

    function automatic t_result apply_request(input t_action act,
                                              input logic [POS_W-1:0] nb,
                                              input logic [OFF_W-1:0] coff);
        t_result     r;
        int unsigned cap, n, wp, rp, cp, mp, f, sum, took;
        bit          empty;
        r.status = ST_OK;
        r.goff   = '0;
        r.gbytes = '0;
        r.wev    = WM_NONE;
        r.nval   = 1'b0;
        r.noff   = '0;
        r.nbytes = '0;
        cap = size_in_use();
        n   = nb;
        wp  = wr_pos;
        rp  = rd_pos;
        cp  = use_pos;
        mp  = mark_pos;
        f   = fill_level;
        empty = (wp == rp) && (f == 0);
        case (act)
            ACT_RESERVE: begin
                if (n > cap) begin
                    r.status = ST_INVALID;
                end else if (run_mode != RUN_ACTIVE) begin
                    r.status = ST_NOT_ACTIVE;
                end else if (wp + n <= cap) begin
                    if (wp <= rp && wp + n > rp && !empty) begin
                        r.status = ST_WOULD_BLOCK;
                    end else begin
                        r.goff = OFF_W'(wp);
                        wr_pos = POS_W'(wp + n);
                    end
                end else if ((rp < n || rp >= wp) && !empty) begin
                    r.status = ST_WOULD_BLOCK;
                end else begin
                    // no room at the end: chunk goes to the start, readers stop at the mark
                    mark_pos   = POS_W'(wp);
                    mark_valid = 1'b1;
                    wr_pos     = POS_W'(n);
                end
            end
            ACT_COMMIT: begin
                sum = f + n;
                fill_level = (sum > FILL_MAX) ? FILL_MAX : FILL_W'(sum);
                if (fill_level > cap) begin
                    r.status = ST_INVALID;
                end else begin
                    r.wev = level_crossing();
                    if (window_open() && cfg_notify) begin
                        if (cp + fill_level > cap) begin
                            r.nval     = 1'b1;
                            r.noff     = OFF_W'(cp);
                            r.nbytes   = POS_W'(fill_level - n);
                            fill_level = FILL_W'(n);
                            use_pos    = '0;
                        end else if (fill_level >= cfg_window) begin
                            took       = fill_level - n;
                            r.nval     = 1'b1;
                            r.noff     = OFF_W'(cp);
                            r.nbytes   = POS_W'(took);
                            fill_level = FILL_W'(n);
                            use_pos    = POS_W'(cp + took);
                        end
                    end
                end
            end
            ACT_FREE: begin
                rd_pos = POS_W'(coff + n);
                r.wev  = level_crossing();
            end
            ACT_READ: begin
                if (n > cap) begin
                    r.status = ST_INVALID;
                end else if (n > f && run_mode != RUN_STOPPED) begin
                    if (run_mode == RUN_ACTIVE) r.status = ST_WOULD_BLOCK;
                    else r.status = ST_NOT_ACTIVE;
                end else begin
                    r.goff = OFF_W'(cp);
                    if (mark_valid && cp + n > mp) begin
                        // only the bytes up to the mark, or a fresh start at 0
                        took = (mp > cp) ? mp - cp : 0;
                        if (took == 0) begin
                            took    = n;
                            r.goff  = '0;
                            use_pos = POS_W'(n);
                        end else begin
                            use_pos = '0;
                        end
                        fill_level = (f > took) ? FILL_W'(f - took) : '0;
                        mark_valid = 1'b0;
                        mark_pos   = '0;
                    end else begin
                        took = n;
                        if (run_mode == RUN_STOPPED && took > f) begin
                            took     = f;
                            r.status = ST_SHORT_READ;
                        end
                        fill_level = FILL_W'(f - took);
                        use_pos    = POS_W'(cp + took);
                    end
                    r.gbytes = POS_W'(took);
                end
            end
            ACT_CANCEL: begin
                run_mode   = RUN_CANCELED;
                fill_level = '0;
            end
            ACT_STOP: run_mode = RUN_STOPPED;
            ACT_RESET: clear_offsets();
            ACT_FLUSH: begin
                if (!window_open() && !cfg_notify) begin
                    r.status = ST_NO_ACCUM;
                end else if (f != 0 && window_open() && cfg_notify) begin
                    r.nval   = 1'b1;
                    r.noff   = OFF_W'(cp);
                    r.nbytes = POS_W'(f);
                end
            end
            default: ;
        endcase
        r.fill = fill_level;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(input t_action act, input int unsigned nb,
                             input int unsigned coff);
        int unsigned gap;
        gap = steady ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid      = 1'b1;
        i_action        = act;
        i_request_bytes = POS_W'(nb);
        i_chunk_offset  = OFF_W'(coff);
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        last_result = apply_request(act, POS_W'(nb), OFF_W'(coff));
        due_results.push_back(last_result);
        words_sent++;
    endtask

    // drop valid and hold off until every result word is back
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned value);
        @(negedge i_clk);
        i_cfg_wen   = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = CFG_W'(value);
        case (idx)
            CFG_BUFFER_BYTES: cfg_size    = POS_W'(value);
            CFG_ACC_WINDOW:   cfg_window  = POS_W'(value);
            CFG_NOTIFY_EN:    cfg_notify  = value[0];
            CFG_WM_EN:        cfg_wm_en   = value[0];
            CFG_WM_LOW:       cfg_wm_low  = POS_W'(value);
            CFG_WM_HIGH:      cfg_wm_high = POS_W'(value);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wen = 1'b0;
    endtask

    task automatic apply_settings(input int unsigned bytes, input int unsigned window,
                                  input int unsigned notify, input int unsigned wm_en,
                                  input int unsigned wm_lo, input int unsigned wm_hi);
        wait_idle();
        write_reg(CFG_BUFFER_BYTES, bytes);
        write_reg(CFG_ACC_WINDOW, window);
        write_reg(CFG_NOTIFY_EN, notify);
        write_reg(CFG_WM_EN, wm_en);
        write_reg(CFG_WM_LOW, wm_lo);
        write_reg(CFG_WM_HIGH, wm_hi);
    endtask

    function automatic int unsigned chunk_bytes(input int unsigned cap);
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 3) return cap;
        if (k < 5) return cap + 1;
        if (k < 8) return 0;
        return $urandom_range(1, cap / 4);
    endfunction

    // mostly reserve/commit/consume rounds, with control actions and noise
    task automatic run_traffic(input int unsigned words);
        int unsigned stop_at, cap, n, avail, k;
        stop_at = words_sent + words;
        cap = size_in_use();
        if ($urandom_range(0, 3) != 0) send_word(ACT_RESET, $urandom, $urandom);
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 149) == 0) wait_idle();
            k = $urandom_range(0, 99);
            if (k < 70) begin
                n = chunk_bytes(cap);
                send_word(ACT_RESERVE, n, $urandom);
                if (last_result.status == ST_OK && $urandom_range(0, 9) != 0)
                    send_word(ACT_COMMIT,
                              ($urandom_range(0, 7) == 0) ? $urandom_range(0, n) : n,
                              $urandom);
                if (window_open() && cfg_notify) begin
                    if (last_result.nval && $urandom_range(0, 3) != 0)
                        send_word(ACT_FREE, last_result.nbytes, last_result.noff);
                    else if ($urandom_range(0, 5) == 0)
                        send_word(ACT_FLUSH, $urandom, $urandom);
                end else if ($urandom_range(0, 2) != 0) begin
                    avail = (fill_level > cap) ? cap : fill_level;
                    n = ($urandom_range(0, 9) == 0) ? avail + 1 : $urandom_range(0, avail);
                    send_word(ACT_READ, n, $urandom);
                    if (last_result.gbytes != 0 && $urandom_range(0, 4) != 0)
                        send_word(ACT_FREE, last_result.gbytes, last_result.goff);
                end
            end else if (k < 78) begin
                avail = (fill_level > cap) ? cap : fill_level;
                send_word(ACT_READ, $urandom_range(0, avail + 2), $urandom);
            end else if (k < 82) begin
                send_word(ACT_FLUSH, $urandom, $urandom);
            end else if (k < 85) begin
                send_word(ACT_STOP, $urandom, $urandom);
            end else if (k < 87) begin
                send_word(ACT_CANCEL, $urandom, $urandom);
            end else if (k < 92) begin
                send_word(ACT_RESET, $urandom, $urandom);
            end else begin
                n = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 131071)
                                                : $urandom_range(0, cap + 2);
                send_word(t_action'($urandom_range(0, 7)), n, $urandom_range(0, 65535));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_request_edges();
        steady = 1'b0;
        send_word(ACT_RESERVE, 131071, 0);          // beyond the buffer
        send_word(ACT_RESERVE, 65536, 65535);       // whole buffer from an empty start
        send_word(ACT_COMMIT, 65536, 0);
        send_word(ACT_COMMIT, 1, 0);                // overfill
        send_word(ACT_READ, 131071, 0);
        send_word(ACT_FLUSH, 0, 0);                 // no window, no listener
        send_word(ACT_RESET, 0, 0);
        send_word(ACT_READ, 1, 0);                  // nothing filled yet
        send_word(ACT_STOP, 0, 0);
        send_word(ACT_COMMIT, 10, 0);
        send_word(ACT_READ, 16, 0);                 // stopped, short read
        send_word(ACT_RESERVE, 4, 0);
        send_word(ACT_CANCEL, 0, 0);
        send_word(ACT_READ, 5, 0);
        send_word(ACT_RESET, 0, 0);
        repeat (3) send_word(ACT_COMMIT, 131071, 0); // fill saturates
        send_word(ACT_FREE, 131071, 65535);
    endtask

    task automatic test_wrap_and_mark();
        apply_settings(16, 0, 0, 0, 0, 0);
        send_word(ACT_RESET, 0, 0);
        send_word(ACT_RESERVE, 10, 0);
        send_word(ACT_COMMIT, 10, 0);
        send_word(ACT_READ, 6, 0);
        send_word(ACT_FREE, 6, 0);
        send_word(ACT_RESERVE, 8, 0);               // wrap would overrun unread data
        send_word(ACT_RESERVE, 6, 0);               // fills to the very end
        send_word(ACT_RESERVE, 5, 0);               // wraps, sets the mark
        send_word(ACT_COMMIT, 11, 0);
        send_word(ACT_READ, 12, 0);                 // cut short at the mark
    endtask

    task automatic test_plain_ring();
        apply_settings(64, 0, 0, 0, 0, 0);
        run_traffic(250);
        steady = 1'b1;
        apply_settings(4096, 0, 0, 0, 0, 0);
        run_traffic(150);
        steady = 1'b0;
    endtask

    task automatic test_watermarks();
        apply_settings(256, 0, 0, 1, 32, 192);
        run_traffic(250);
        apply_settings(16, 0, 0, 1, 0, 16);         // high mark at the buffer size
        run_traffic(100);
        apply_settings(128, 0, 0, 1, 100, 50);      // low above high: out of force
        run_traffic(80);
        apply_settings(64, 0, 0, 1, 8, 65);         // high above the buffer
        run_traffic(60);
    endtask

    task automatic test_accumulation();
        apply_settings(1024, 128, 1, 1, 100, 800);
        run_traffic(250);
        steady = 1'b1;
        apply_settings(16, 8, 1, 0, 0, 0);          // window at half the buffer
        run_traffic(150);
        steady = 1'b0;
        apply_settings(512, 64, 0, 0, 0, 0);        // window but no listener
        run_traffic(100);
        apply_settings(4096, 2049, 1, 0, 0, 0);     // window above half: off
        run_traffic(80);
        apply_settings(256, 0, 1, 0, 0, 0);
        run_traffic(60);
    endtask

    task automatic test_size_extremes();
        apply_settings(65536, 1, 1, 1, 1000, 65536);
        run_traffic(150);
        apply_settings(131071, 65536, 0, 0, 65536, 0);
        run_traffic(80);
        apply_settings(1, 1, 0, 1, 0, 1);
        run_traffic(60);
        apply_settings(0, 1, 1, 1, 0, 1);           // zero acts as one byte
        run_traffic(60);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("word %0d: %s expected %0d, got %0d",
                         results_seen, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word %0d: result with nothing outstanding", results_seen);
            end else begin
                want = due_results.pop_front();
                check_field("status", want.status, o_status);
                check_field("grant_offset", want.goff, o_grant_offset);
                check_field("grant_bytes", want.gbytes, o_grant_bytes);
                check_field("wm_event", want.wev, o_wm_event);
                check_field("notify_valid", want.nval, o_notify_valid);
                check_field("notify_offset", want.noff, o_notify_offset);
                check_field("notify_bytes", want.nbytes, o_notify_bytes);
                check_field("fill_bytes", want.fill, o_fill_bytes);
            end
            results_seen++;
        end
    end

    // result back-pressure
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (steady || $urandom_range(0, 2) != 0) begin
                i_out_ready = 1'b1;
            end else begin
                i_out_ready = 1'b0;
                repeat (pick_gap()) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wen       = 1'b0;
        i_cfg_index     = CFG_BUFFER_BYTES;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_action        = ACT_RESERVE;
        i_request_bytes = '0;
        i_chunk_offset  = '0;
        words_sent      = 0;
        results_seen    = 0;
        mismatches      = 0;
        cycle_count     = 0;
        steady          = 1'b0;
        cfg_size        = MAX_SIZE;
        cfg_window      = '0;
        cfg_notify      = 1'b0;
        cfg_wm_en       = 1'b0;
        cfg_wm_low      = '0;
        cfg_wm_high     = '0;
        clear_offsets();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_request_edges();
        test_wrap_and_mark();
        test_plain_ring();
        test_watermarks();
        test_accumulation();
        test_size_extremes();

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/rbsm_pkg.sv
hdl/rbsm_ctrl.sv
hdl/rbsm_dp.sv
hdl/ring_buffer_space_manager.sv
verif/ring_buffer_space_manager_test.sv
